/* hw/rtl/hcp_pkg.sv */
// shared constants and types of the huffman code packer
`default_nettype none
package hcp_pkg;

    localparam int SYM_W        = 8;
    localparam int WORD_W       = 32;
    localparam int LEN_W        = 6;
    localparam int CMD_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int TOTAL_W      = 32;
    localparam int WIDE_W       = 64;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 40;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic              flush;
        logic [WORD_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } t_op;

endpackage
`default_nettype wire

/* hw/rtl/huffman_code_packer.sv */
// static huffman encoder, msb first, with loadable code table
// an encode passes the table read register, the op queue and the bit buffer to the output register
// throughput: the front takes one item per cycle while the op queue has room;
// the bit packer takes an encode or flush op only when idle and emits its bytes before the next op
// reset: synchronous active-low, clears bit buffer, bit count and the op queue;
// the code table is not cleared and must be loaded before use
`default_nettype none
module huffman_code_packer #(
    parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcp_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // symbol, code_word, code_length, zero pad
    input  wire logic [hcp_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  wire logic [hcp_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // out_byte, total_bits
    output logic [hcp_pkg::M_TDATA_W-1:0]          m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int WORD_LO = hcp_pkg::SYM_W;
    localparam int LEN_LO  = WORD_LO + hcp_pkg::WORD_W;

    logic                         push;
    hcp_pkg::t_op                 push_op;
    logic                         pop;
    logic                         q_valid;
    hcp_pkg::t_op                 q_op;
    logic [hcp_pkg::Q_CW-1:0]     q_count;
    logic [hcp_pkg::BYTE_W-1:0]   out_byte;
    logic [hcp_pkg::TOTAL_W-1:0]  out_total;

    hcp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_cmd         (s_axis_tuser),
        .i_symbol      (s_axis_tdata[hcp_pkg::SYM_W-1:0]),
        .i_code_word   (s_axis_tdata[LEN_LO-1:WORD_LO]),
        .i_code_length (s_axis_tdata[LEN_LO+hcp_pkg::LEN_W-1:LEN_LO]),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_op          (push_op)
    );

    hcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_count (q_count)
    );

    hcp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (out_byte),
        .o_last    (m_axis_tlast),
        .o_total   (out_total)
    );

    assign m_axis_tdata = {out_total, out_byte};

endmodule
`default_nettype wire

/* hw/rtl/hcp_front.sv */
// front end: takes items, holds the code table, queues encode and flush ops
`default_nettype none
module hcp_front #(
    parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hcp_pkg::SYMBOL_COUNT_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [hcp_pkg::CMD_W-1:0]    i_cmd,
    input  wire logic [hcp_pkg::SYM_W-1:0]    i_symbol,
    input  wire logic [hcp_pkg::WORD_W-1:0]   i_code_word,
    input  wire logic [hcp_pkg::LEN_W-1:0]    i_code_length,
    input  wire logic [hcp_pkg::Q_CW-1:0]     i_q_count,
    output logic                              o_push,
    output hcp_pkg::t_op                      o_op
);

    localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    logic [hcp_pkg::WORD_W-1:0] r_mem_word [SYMBOL_COUNT];
    logic [LW-1:0]              r_mem_len  [SYMBOL_COUNT];
    logic [hcp_pkg::WORD_W-1:0] r_rd_word;
    logic [LW-1:0]              r_rd_len;
    logic                       r_s1_valid;
    logic                       r_s1_flush;

    logic                        accept;
    logic                        in_range;
    logic [AW-1:0]               idx;
    logic [hcp_pkg::LEN_W-1:0]   sat_len;
    logic [hcp_pkg::WIDE_W-1:0]  mask;
    logic                        is_load;
    logic                        is_encode;
    logic                        is_flush;

    assign accept   = i_valid && o_ready;
    assign in_range = {1'b0, i_symbol} < (hcp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
    assign idx      = i_symbol[AW-1:0];
    assign sat_len  = (i_code_length > hcp_pkg::LEN_W'(MAX_CODE_LEN)) ?
                      hcp_pkg::LEN_W'(MAX_CODE_LEN) : i_code_length;
    assign mask     = ~({hcp_pkg::WIDE_W{1'b1}} << sat_len);

    always_comb begin
        is_load   = 1'b0;
        is_encode = 1'b0;
        is_flush  = 1'b0;
        case (i_cmd)
            hcp_pkg::CMD_LOAD:   is_load   = 1'b1;
            hcp_pkg::CMD_ENCODE: is_encode = 1'b1;
            hcp_pkg::CMD_FLUSH:  is_flush  = 1'b1;
            default: begin
            end
        endcase
    end

    // room for the queue contents plus the op in flight
    assign o_ready = ((hcp_pkg::Q_CW + 1)'(i_q_count) + (hcp_pkg::Q_CW + 1)'(r_s1_valid))
                     < (hcp_pkg::Q_CW + 1)'(hcp_pkg::Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (accept && is_load && in_range) begin
            r_mem_word[idx] <= i_code_word & mask[hcp_pkg::WORD_W-1:0];
            r_mem_len[idx]  <= sat_len[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_word <= r_mem_word[idx];
        r_rd_len  <= r_mem_len[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            r_s1_valid <= accept && ((is_encode && in_range) || is_flush);
            r_s1_flush <= is_flush;
        end
    end

    assign o_push     = r_s1_valid;
    assign o_op.flush = r_s1_flush;
    assign o_op.word  = r_rd_word;
    assign o_op.len   = hcp_pkg::LEN_W'(r_rd_len);

endmodule
`default_nettype wire

/* hw/rtl/hcp_queue.sv */
// short op queue between front end and bit packer
`default_nettype none
module hcp_queue (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire hcp_pkg::t_op             i_op,
    input  wire logic                     i_pop,
    output logic                          o_valid,
    output hcp_pkg::t_op                  o_op,
    output logic [hcp_pkg::Q_CW-1:0]      o_count
);

    hcp_pkg::t_op                r_mem [hcp_pkg::Q_DEPTH];
    logic [hcp_pkg::Q_AW-1:0]    r_wr;
    logic [hcp_pkg::Q_AW-1:0]    r_rd;
    logic [hcp_pkg::Q_CW-1:0]    r_count;
    logic                        do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + hcp_pkg::Q_CW'(i_push) - hcp_pkg::Q_CW'(do_pop);
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/hcp_back.sv */
// back end: appends code bits to the bit buffer and emits bytes msb first; a flush emits the zero-padded last byte
`default_nettype none
module hcp_back #(
    parameter int MAX_CODE_LEN = hcp_pkg::MAX_CODE_LEN_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    input  wire hcp_pkg::t_op                 i_q_op,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [hcp_pkg::BYTE_W-1:0]        o_byte,
    output logic                              o_last,
    output logic [hcp_pkg::TOTAL_W-1:0]       o_total
);

    localparam int BUF_W = MAX_CODE_LEN + hcp_pkg::BYTE_W - 1;
    localparam int CW    = $clog2(BUF_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [BUF_W-1:0]            r_buf, n_buf;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [hcp_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        r_out_valid, n_out_valid;
    logic [hcp_pkg::BYTE_W-1:0]  r_out_byte, n_out_byte;
    logic                        r_out_last, n_out_last;
    logic [hcp_pkg::TOTAL_W-1:0] r_out_total, n_out_total;

    logic                        out_free;
    logic [CW-1:0]               clen;
    logic [CW-1:0]               sh;
    logic [hcp_pkg::WIDE_W-1:0]  wide;
    logic [CW-1:0]               rem;

    assign out_free = !r_out_valid || i_ready;
    assign clen     = CW'(i_q_op.len);
    assign sh       = CW'(BUF_W) - r_cnt - clen;
    assign wide     = hcp_pkg::WIDE_W'(i_q_op.word) << sh;
    assign rem      = r_cnt - CW'(hcp_pkg::BYTE_W);

    always_comb begin
        n_state     = r_state;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_total = r_out_total;
        o_pop       = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop = 1'b1;
                    if (i_q_op.flush) begin
                        if (r_cnt != '0) begin
                            n_state = ST_FLUSH;
                        end else begin
                            n_total = '0;
                        end
                    end else begin
                        n_buf   = r_buf | wide[BUF_W-1:0];
                        n_cnt   = r_cnt + clen;
                        n_total = r_total + hcp_pkg::TOTAL_W'(i_q_op.len);
                        if (n_cnt >= CW'(hcp_pkg::BYTE_W)) begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_buf[BUF_W-1 -: hcp_pkg::BYTE_W];
                    n_out_last  = rem < CW'(hcp_pkg::BYTE_W);
                    n_out_total = r_total;
                    n_buf       = r_buf << hcp_pkg::BYTE_W;
                    n_cnt       = rem;
                    if (rem < CW'(hcp_pkg::BYTE_W)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_buf[BUF_W-1 -: hcp_pkg::BYTE_W];
                    n_out_last  = 1'b1;
                    n_out_total = r_total;
                    n_buf       = '0;
                    n_cnt       = '0;
                    n_total     = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_buf       <= '0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_buf       <= n_buf;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_out_total <= n_out_total;
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_total = r_out_total;

endmodule
`default_nettype wire
